FILE: design/coons_patch_vertex_evaluator_core_assert.svh
// Assertion macros shared by the checker of the Coons patch vertex evaluator.
`ifndef COONS_PATCH_VERTEX_EVALUATOR_CORE_ASSERT_SVH
`define COONS_PATCH_VERTEX_EVALUATOR_CORE_ASSERT_SVH

// Same-cycle implication, switched off during reset.
`define CPVE_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, switched off during reset.
`define CPVE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Same-cycle implication that is checked during reset as well.
`define CPVE_ASSERT_ALWAYS(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |-> (cons)) \
        else $error(msg);

`endif

FILE: design/cpve_pkg.sv
// Shared types and constants of the Coons patch vertex evaluator.
`timescale 1ns / 1ps

package cpve_pkg;

    localparam int PARAM_W   = 17;   // s and t in Q0.16, 1.0 included
    localparam int WQ_W      = 25;   // Bezier weight in Q0.24, 1.0 included
    localparam int DIM_W     = 9;
    localparam int IDX_W     = 8;
    localparam int VIDX_W    = 16;
    localparam int SLOT_W    = 4;
    localparam int DIV_STEPS = PARAM_W;
    localparam int CURVES    = 4;
    localparam int POINTS    = 16;
    localparam int AXES      = 3;
    localparam int CFG_IDX_W = 1;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_EVAL = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_GRID_COLS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_ROWS = 1'd1;

    localparam logic [DIM_W-1:0] GRID_RESET = 9'd20;

    typedef struct packed {
        logic                is_eval;
        logic [SLOT_W-1:0]   slot;
        logic [PARAM_W-1:0]  s;
        logic [PARAM_W-1:0]  t;
        logic [VIDX_W-1:0]   vidx;
    } cpve_tag_t;

    typedef struct packed {
        logic [DIM_W-1:0]   rem;
        logic [PARAM_W-1:0] num;
        logic [PARAM_W-1:0] quo;
    } cpve_div_t;

endpackage

FILE: design/coons_patch_vertex_evaluator_core.sv
// Top level of the Coons patch vertex evaluator.
`timescale 1ns / 1ps

// Evaluates a bilinearly blended Coons patch with four cubic Bezier boundaries.
// Load beats write one of sixteen control points and give no result; evaluate
// beats return the surface position and vertex index for one grid vertex. The
// block takes one beat every cycle while in_stall is low. Each evaluate beat
// passes through the front part, where a restoring divider resolves one bit of
// s and t per stage, then through the queue and last through the back part,
// whose weight, curve and blend multipliers are each followed by a register. A
// load takes effect for every evaluate beat accepted after it. The control
// points are all zero after reset and the grid is 20 by 20. Configuration
// writes are taken in any cycle and are to be made only while no beat is in
// flight.
module coons_patch_vertex_evaluator_core
    import cpve_pkg::*;
#(
    parameter int COORD_WIDTH  = 24,
    parameter int MAX_GRID_DIM = 256
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          operation,
    input  logic [SLOT_W-1:0]             point_index,
    input  logic signed [COORD_WIDTH-1:0] coord_x,
    input  logic signed [COORD_WIDTH-1:0] coord_y,
    input  logic signed [COORD_WIDTH-1:0] coord_z,
    input  logic [IDX_W-1:0]              col_index,
    input  logic [IDX_W-1:0]              row_index,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [COORD_WIDTH-1:0] pos_x,
    output logic signed [COORD_WIDTH-1:0] pos_y,
    output logic signed [COORD_WIDTH-1:0] pos_z,
    output logic [VIDX_W-1:0]             vertex_index,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [CFG_IDX_W-1:0]          cfg_index,
    input  logic [DIM_W-1:0]              cfg_data
);

    localparam int CRD_W = 3 * COORD_WIDTH;
    localparam int Q_W   = $bits(cpve_tag_t) + CRD_W;

    logic [DIM_W-1:0] grid_cols_reg;
    logic [DIM_W-1:0] grid_rows_reg;

    logic             f_valid;
    logic             q_stall;
    cpve_tag_t        f_tag;
    logic [CRD_W-1:0] f_coords;
    logic             q_valid;
    logic             b_pop;
    logic [Q_W-1:0]   q_data;
    cpve_tag_t        q_tag;
    logic [CRD_W-1:0] q_coords;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_cols_reg <= GRID_RESET;
            grid_rows_reg <= GRID_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_GRID_COLS: grid_cols_reg <= cfg_data;
                CFG_GRID_ROWS: grid_rows_reg <= cfg_data;
                default:       grid_cols_reg <= grid_cols_reg;
            endcase
        end
    end

    cpve_front #(
        .COORD_WIDTH  (COORD_WIDTH),
        .MAX_GRID_DIM (MAX_GRID_DIM)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .operation   (operation),
        .point_index (point_index),
        .coords      ({coord_z, coord_y, coord_x}),
        .col_index   (col_index),
        .row_index   (row_index),
        .grid_cols   (grid_cols_reg),
        .grid_rows   (grid_rows_reg),
        .out_valid   (f_valid),
        .out_stall   (q_stall),
        .out_tag     (f_tag),
        .out_coords  (f_coords)
    );

    cpve_queue #(
        .DATA_W (Q_W),
        .DEPTH  (4)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (f_valid),
        .push_stall (q_stall),
        .push_data  ({f_tag, f_coords}),
        .pop_valid  (q_valid),
        .pop_ack    (b_pop),
        .pop_data   (q_data)
    );

    assign q_tag    = q_data[Q_W-1:CRD_W];
    assign q_coords = q_data[CRD_W-1:0];

    cpve_back #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (q_valid),
        .in_pop       (b_pop),
        .in_tag       (q_tag),
        .in_coords    (q_coords),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .pos_z        (pos_z),
        .vertex_index (vertex_index)
    );

endmodule

FILE: design/cpve_front.sv
// Front part: accepts items, clamps the grid indices and divides out s and t.
`timescale 1ns / 1ps

module cpve_front
    import cpve_pkg::*;
#(
    parameter int COORD_WIDTH  = 24,
    parameter int MAX_GRID_DIM = 256
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic                     operation,
    input  logic [SLOT_W-1:0]        point_index,
    input  logic [3*COORD_WIDTH-1:0] coords,
    input  logic [IDX_W-1:0]         col_index,
    input  logic [IDX_W-1:0]         row_index,
    input  logic [DIM_W-1:0]         grid_cols,
    input  logic [DIM_W-1:0]         grid_rows,
    output logic                     out_valid,
    input  logic                     out_stall,
    output cpve_tag_t                out_tag,
    output logic [3*COORD_WIDTH-1:0] out_coords
);

    localparam int STAGES = DIV_STEPS;

    logic                     valid_reg  [STAGES];
    cpve_tag_t                tag_reg    [STAGES];
    logic [3*COORD_WIDTH-1:0] crd_reg    [STAGES];
    cpve_div_t                divs_reg   [STAGES];
    cpve_div_t                divt_reg   [STAGES];

    logic [DIM_W-1:0]   cols_eff;
    logic [DIM_W-1:0]   rows_eff;
    logic [DIM_W-1:0]   dc;
    logic [DIM_W-1:0]   dr;
    logic [IDX_W-1:0]   i_cl;
    logic [IDX_W-1:0]   j_cl;
    logic [23:0]        num_s;
    logic [23:0]        num_t;
    cpve_tag_t          tag_next;
    cpve_div_t          divs_next;
    cpve_div_t          divt_next;
    logic               adv;

    function automatic logic [DIM_W-1:0] eff_dim(logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] r;
        r = v;
        if (v < 9'd2)
        begin
            r = 9'd2;
        end
        else if (32'(v) > MAX_GRID_DIM)
        begin
            r = DIM_W'(MAX_GRID_DIM);
        end
        return r;
    endfunction

    // One restoring step: one quotient bit.
    function automatic cpve_div_t div_step(cpve_div_t d, logic [DIM_W-1:0] dv);
        logic [DIM_W:0] trial;
        logic           ge;
        cpve_div_t      r;
        trial = {d.rem, d.num[PARAM_W-1]};
        ge    = trial >= {1'b0, dv};
        r.rem = ge ? DIM_W'(trial - {1'b0, dv}) : trial[DIM_W-1:0];
        r.num = {d.num[PARAM_W-2:0], 1'b0};
        r.quo = {d.quo[PARAM_W-2:0], ge};
        return r;
    endfunction

    assign adv      = !out_stall;
    assign in_stall = out_stall;

    always_comb
    begin
        cols_eff = eff_dim(grid_cols);
        rows_eff = eff_dim(grid_rows);
        dc       = cols_eff - 9'd1;
        dr       = rows_eff - 9'd1;
        i_cl     = ({1'b0, col_index} > dc) ? dc[IDX_W-1:0] : col_index;
        j_cl     = ({1'b0, row_index} > dr) ? dr[IDX_W-1:0] : row_index;
        // Numerator i*65536 + (cols-1)/2; the quotient never exceeds 17 bits.
        num_s    = {i_cl, 16'd0} + {15'd0, dc[DIM_W-1:1]};
        num_t    = {j_cl, 16'd0} + {15'd0, dr[DIM_W-1:1]};

        divs_next.rem = {2'd0, num_s[23:17]};
        divs_next.num = num_s[16:0];
        divs_next.quo = '0;
        divt_next.rem = {2'd0, num_t[23:17]};
        divt_next.num = num_t[16:0];
        divt_next.quo = '0;

        tag_next.is_eval = (operation == OP_EVAL);
        tag_next.slot    = point_index;
        tag_next.s       = '0;
        tag_next.t       = '0;
        tag_next.vidx    = VIDX_W'(17'(i_cl) + 17'(j_cl) * 17'(cols_eff));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < STAGES; k++)
            begin
                valid_reg[k] <= 1'b0;
            end
        end
        else if (adv)
        begin
            valid_reg[0] <= in_valid;
            for (int k = 1; k < STAGES; k++)
            begin
                valid_reg[k] <= valid_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            tag_reg[0]  <= tag_next;
            crd_reg[0]  <= coords;
            divs_reg[0] <= divs_next;
            divt_reg[0] <= divt_next;
            for (int k = 1; k < STAGES; k++)
            begin
                tag_reg[k]  <= tag_reg[k-1];
                crd_reg[k]  <= crd_reg[k-1];
                divs_reg[k] <= div_step(divs_reg[k-1], dc);
                divt_reg[k] <= div_step(divt_reg[k-1], dr);
            end
        end
    end

    // The last quotient bit is resolved on the way into the queue.
    always_comb
    begin
        out_valid  = valid_reg[STAGES-1];
        out_coords = crd_reg[STAGES-1];
        out_tag    = tag_reg[STAGES-1];
        out_tag.s  = div_step(divs_reg[STAGES-1], dc).quo;
        out_tag.t  = div_step(divt_reg[STAGES-1], dr).quo;
    end

endmodule

FILE: design/cpve_queue.sv
// Short queue that decouples the front part from the back part.
`timescale 1ns / 1ps

module cpve_queue
    import cpve_pkg::*;
#(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 4
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push_valid,
    output logic              push_stall,
    input  logic [DATA_W-1:0] push_data,
    output logic              pop_valid,
    input  logic              pop_ack,
    output logic [DATA_W-1:0] pop_data
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              push;
    logic              pop;

    assign push_stall = (count_reg == CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign push       = push_valid && !push_stall;
    assign pop        = pop_ack && pop_valid;
    assign pop_data   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

FILE: design/cpve_back.sv
// Back part: control point store, Bezier weights, curve sums and Coons blend.
`timescale 1ns / 1ps

module cpve_back
    import cpve_pkg::*;
#(
    parameter int COORD_WIDTH = 24
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_pop,
    input  cpve_tag_t                     in_tag,
    input  logic [3*COORD_WIDTH-1:0]      in_coords,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [COORD_WIDTH-1:0] pos_x,
    output logic signed [COORD_WIDTH-1:0] pos_y,
    output logic signed [COORD_WIDTH-1:0] pos_z,
    output logic [VIDX_W-1:0]             vertex_index
);

    localparam int CW  = COORD_WIDTH;
    localparam int PW  = CW + WQ_W + 1;   // weight times point
    localparam int AW  = PW + 2;          // sum of four products
    localparam int BW  = CW + 2;          // curve point, may overshoot slightly
    localparam int LPW = CW + 1 + PARAM_W + 1;
    localparam int LBW = BW + 1 + PARAM_W + 1;
    localparam int SW  = BW + 2;
    localparam int MW  = 52;

    localparam logic signed [SW-1:0] SAT_HI = $signed({{(SW-CW+1){1'b0}}, {(CW-1){1'b1}}});
    localparam logic signed [SW-1:0] SAT_LO = ~SAT_HI;

    logic                 adv;

    logic signed [CW-1:0] pts_reg [POINTS][AXES];

    // stage 1: squares and cross terms
    logic                 b1_valid_reg;
    cpve_tag_t            b1_tag_reg;
    logic signed [CW-1:0] b1_crd_reg [AXES];
    logic [PARAM_W-1:0]   b1_u_reg   [2];
    logic [PARAM_W-1:0]   b1_p_reg   [2];
    logic [33:0]          b1_u2_reg  [2];
    logic [33:0]          b1_us_reg  [2];
    logic [33:0]          b1_s2_reg  [2];

    // stage 2: rounded weights
    logic                 b2_valid_reg;
    cpve_tag_t            b2_tag_reg;
    logic signed [CW-1:0] b2_crd_reg [AXES];
    logic [WQ_W-1:0]      b2_wq_reg  [2][4];

    // stage 3: weighted points, store is read here
    logic                 b3_valid_reg;
    cpve_tag_t            b3_tag_reg;
    logic signed [PW-1:0] b3_prod_reg [CURVES][4][AXES];
    logic signed [CW-1:0] b3_c0_reg [AXES];
    logic signed [CW-1:0] b3_c3_reg [AXES];
    logic signed [CW-1:0] b3_c4_reg [AXES];
    logic signed [CW-1:0] b3_c7_reg [AXES];

    // stage 4: curve points and edge products
    logic                  b4_valid_reg;
    cpve_tag_t             b4_tag_reg;
    logic signed [BW-1:0]  b4_bez_reg [CURVES][AXES];
    logic signed [LPW-1:0] b4_pe0_reg [AXES];
    logic signed [LPW-1:0] b4_pe1_reg [AXES];
    logic signed [CW-1:0]  b4_p0_reg  [AXES];
    logic signed [CW-1:0]  b4_p4_reg  [AXES];

    // stage 5
    logic                  b5_valid_reg;
    cpve_tag_t             b5_tag_reg;
    logic signed [LBW-1:0] b5_plc_reg  [AXES];
    logic signed [LBW-1:0] b5_pld_reg  [AXES];
    logic signed [BW-1:0]  b5_bez0_reg [AXES];
    logic signed [BW-1:0]  b5_bez2_reg [AXES];
    logic signed [CW-1:0]  b5_e0_reg   [AXES];
    logic signed [CW-1:0]  b5_e1_reg   [AXES];

    // stage 6
    logic                  b6_valid_reg;
    cpve_tag_t             b6_tag_reg;
    logic signed [BW-1:0]  b6_lc_reg  [AXES];
    logic signed [BW-1:0]  b6_ld_reg  [AXES];
    logic signed [LPW-1:0] b6_pbl_reg [AXES];
    logic signed [CW-1:0]  b6_e0_reg  [AXES];

    // stage 7: result register
    logic                  out_valid_reg;
    logic signed [CW-1:0]  pos_reg [AXES];
    logic [VIDX_W-1:0]     vidx_reg;

    logic                  load_write;

    assign adv        = !(out_valid_reg && out_stall);
    assign in_pop     = adv && in_valid;
    assign load_write = adv && b2_valid_reg && !b2_tag_reg.is_eval;

    assign out_valid    = out_valid_reg;
    assign pos_x        = pos_reg[0];
    assign pos_y        = pos_reg[1];
    assign pos_z        = pos_reg[2];
    assign vertex_index = vidx_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_valid_reg  <= 1'b0;
            b2_valid_reg  <= 1'b0;
            b3_valid_reg  <= 1'b0;
            b4_valid_reg  <= 1'b0;
            b5_valid_reg  <= 1'b0;
            b6_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            b1_valid_reg  <= in_valid;
            b2_valid_reg  <= b1_valid_reg;
            // Loads end at the store and go no further.
            b3_valid_reg  <= b2_valid_reg && b2_tag_reg.is_eval;
            b4_valid_reg  <= b3_valid_reg;
            b5_valid_reg  <= b4_valid_reg;
            b6_valid_reg  <= b5_valid_reg;
            out_valid_reg <= b6_valid_reg;
        end
    end

    // Loads write in the same stage that evaluates read, so order is kept.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int p = 0; p < POINTS; p++)
            begin
                for (int a = 0; a < AXES; a++)
                begin
                    pts_reg[p][a] <= '0;
                end
            end
        end
        else if (load_write)
        begin
            for (int a = 0; a < AXES; a++)
            begin
                pts_reg[b2_tag_reg.slot][a] <= b2_crd_reg[a];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        logic [PARAM_W-1:0]    prm;
        logic [PARAM_W-1:0]    u;
        logic [MW-1:0]         w [4];
        logic signed [AW-1:0]  acc;
        logic signed [CW:0]    dp;
        logic signed [BW:0]    db;
        logic signed [LPW-1:0] rl;
        logic signed [LBW-1:0] rb;
        logic signed [SW-1:0]  sum;
        logic signed [CW-1:0]  bl;
        if (adv)
        begin
            // stage 1
            b1_tag_reg <= in_tag;
            for (int a = 0; a < AXES; a++)
            begin
                b1_crd_reg[a] <= in_coords[a*CW +: CW];
            end
            for (int p = 0; p < 2; p++)
            begin
                prm = (p == 0) ? in_tag.s : in_tag.t;
                u   = 17'd65536 - prm;
                b1_p_reg[p]  <= prm;
                b1_u_reg[p]  <= u;
                b1_u2_reg[p] <= 34'(u) * 34'(u);
                b1_us_reg[p] <= 34'(u) * 34'(prm);
                b1_s2_reg[p] <= 34'(prm) * 34'(prm);
            end

            // stage 2: exact Q0.48 weights rounded to Q0.24, half up
            b2_tag_reg <= b1_tag_reg;
            b2_crd_reg <= b1_crd_reg;
            for (int p = 0; p < 2; p++)
            begin
                w[0] = MW'(b1_u2_reg[p]) * MW'(b1_u_reg[p]);
                w[1] = MW'(3) * MW'(b1_us_reg[p]) * MW'(b1_u_reg[p]);
                w[2] = MW'(3) * MW'(b1_us_reg[p]) * MW'(b1_p_reg[p]);
                w[3] = MW'(b1_s2_reg[p]) * MW'(b1_p_reg[p]);
                for (int k = 0; k < 4; k++)
                begin
                    b2_wq_reg[p][k] <= WQ_W'((w[k] + MW'(24'd8388608)) >> 24);
                end
            end

            // stage 3
            b3_tag_reg <= b2_tag_reg;
            for (int a = 0; a < AXES; a++)
            begin
                for (int c = 0; c < CURVES; c++)
                begin
                    for (int k = 0; k < 4; k++)
                    begin
                        b3_prod_reg[c][k][a] <= $signed({1'b0, b2_wq_reg[c >> 1][k]})
                                                * pts_reg[c*4 + k][a];
                    end
                end
                b3_c0_reg[a] <= pts_reg[0][a];
                b3_c3_reg[a] <= pts_reg[3][a];
                b3_c4_reg[a] <= pts_reg[4][a];
                b3_c7_reg[a] <= pts_reg[7][a];
            end

            // stage 4
            b4_tag_reg <= b3_tag_reg;
            for (int a = 0; a < AXES; a++)
            begin
                for (int c = 0; c < CURVES; c++)
                begin
                    acc = AW'(b3_prod_reg[c][0][a]) + AW'(b3_prod_reg[c][1][a])
                        + AW'(b3_prod_reg[c][2][a]) + AW'(b3_prod_reg[c][3][a])
                        + AW'(32'sd8388608);
                    b4_bez_reg[c][a] <= BW'(acc >>> 24);
                end
                dp = (CW+1)'(b3_c3_reg[a]) - (CW+1)'(b3_c0_reg[a]);
                b4_pe0_reg[a] <= $signed({1'b0, b3_tag_reg.s}) * dp;
                dp = (CW+1)'(b3_c7_reg[a]) - (CW+1)'(b3_c4_reg[a]);
                b4_pe1_reg[a] <= $signed({1'b0, b3_tag_reg.s}) * dp;
                b4_p0_reg[a]  <= b3_c0_reg[a];
                b4_p4_reg[a]  <= b3_c4_reg[a];
            end

            // stage 5
            b5_tag_reg <= b4_tag_reg;
            for (int a = 0; a < AXES; a++)
            begin
                db = (BW+1)'(b4_bez_reg[1][a]) - (BW+1)'(b4_bez_reg[0][a]);
                b5_plc_reg[a] <= $signed({1'b0, b4_tag_reg.t}) * db;
                db = (BW+1)'(b4_bez_reg[3][a]) - (BW+1)'(b4_bez_reg[2][a]);
                b5_pld_reg[a] <= $signed({1'b0, b4_tag_reg.s}) * db;
                b5_bez0_reg[a] <= b4_bez_reg[0][a];
                b5_bez2_reg[a] <= b4_bez_reg[2][a];
                rl = (b4_pe0_reg[a] + LPW'(32'sd32768)) >>> 16;
                b5_e0_reg[a] <= b4_p0_reg[a] + CW'(rl);
                rl = (b4_pe1_reg[a] + LPW'(32'sd32768)) >>> 16;
                b5_e1_reg[a] <= b4_p4_reg[a] + CW'(rl);
            end

            // stage 6
            b6_tag_reg <= b5_tag_reg;
            for (int a = 0; a < AXES; a++)
            begin
                rb = (b5_plc_reg[a] + LBW'(32'sd32768)) >>> 16;
                b6_lc_reg[a] <= b5_bez0_reg[a] + BW'(rb);
                rb = (b5_pld_reg[a] + LBW'(32'sd32768)) >>> 16;
                b6_ld_reg[a] <= b5_bez2_reg[a] + BW'(rb);
                dp = (CW+1)'(b5_e1_reg[a]) - (CW+1)'(b5_e0_reg[a]);
                b6_pbl_reg[a] <= $signed({1'b0, b5_tag_reg.t}) * dp;
                b6_e0_reg[a]  <= b5_e0_reg[a];
            end

            // stage 7: blend and saturate
            vidx_reg <= b6_tag_reg.vidx;
            for (int a = 0; a < AXES; a++)
            begin
                rl  = (b6_pbl_reg[a] + LPW'(32'sd32768)) >>> 16;
                bl  = b6_e0_reg[a] + CW'(rl);
                sum = SW'(b6_lc_reg[a]) + SW'(b6_ld_reg[a]) - SW'(bl);
                if (sum > SAT_HI)
                begin
                    pos_reg[a] <= CW'(SAT_HI);
                end
                else if (sum < SAT_LO)
                begin
                    pos_reg[a] <= CW'(SAT_LO);
                end
                else
                begin
                    pos_reg[a] <= CW'(sum);
                end
            end
        end
    end

endmodule

FILE: design/coons_patch_vertex_evaluator_core_checker.sv
// Port-level checker of the Coons patch vertex evaluator and its bind.
`timescale 1ns / 1ps
`include "coons_patch_vertex_evaluator_core_assert.svh"

module coons_patch_vertex_evaluator_core_checker
    import cpve_pkg::*;
#(
    parameter int COORD_WIDTH = 24
)
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   in_stall,
    input logic                   out_valid,
    input logic                   out_stall,
    input logic [COORD_WIDTH-1:0] pos_x,
    input logic [COORD_WIDTH-1:0] pos_y,
    input logic [COORD_WIDTH-1:0] pos_z,
    input logic [VIDX_W-1:0]      vertex_index
);

    `CPVE_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(vertex_index) && $stable(pos_x) && $stable(pos_y) && $stable(pos_z), "result beat changed while stalled")

    // The queue can only fill while the result side holds the back part.
    `CPVE_ASSERT_IMPL(a_in_backpressure, clk, rst_n, in_stall, $past(out_valid && out_stall), "input stalled without a stalled result")

    `CPVE_ASSERT_ALWAYS(a_reset_quiet, clk, !rst_n, !out_valid && !in_stall, "handshake active during reset")

endmodule

bind coons_patch_vertex_evaluator_core coons_patch_vertex_evaluator_core_checker #(
    .COORD_WIDTH (COORD_WIDTH)
) u_checker (.*);
